// ===== hw/rtl/assert_macros.svh =====
// ---------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion wrappers, empty when synthesizing
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`else

`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg)

`define ASSERT_NEXT(label, clk, rst, ante, cons, msg)

`endif

`endif

// ===== hw/rtl/cpf_pkg.sv =====
// ---------------------------------------------------------------------------
// cpf_pkg
// types, constants and mod-11 helpers for the cpf check digit pipeline
// ---------------------------------------------------------------------------
`default_nettype none

package cpf_pkg;

  localparam int unsigned ID_W     = 37;
  localparam int unsigned DIGIT_W  = 4;
  localparam int unsigned NUM_POS  = 10;

  localparam logic [ID_W-1:0]    SPAN   = 37'd100000000000;
  localparam logic [DIGIT_W-1:0] MOD11  = 4'd11;
  localparam logic [DIGIT_W-1:0] RADIX  = 4'd10;
  localparam logic [DIGIT_W-1:0] LOW_R  = 4'd2;

  typedef struct packed {
    logic [ID_W-1:0]    x;
    logic [DIGIT_W-1:0] r1;
    logic [DIGIT_W-1:0] r2;
    logic [DIGIT_W-1:0] d9;
  } stage_t;

  function automatic logic [ID_W-1:0] pow10(input int n);
    logic [ID_W-1:0] p;
    p = 37'd1;
    for (int i = 0; i < n; i++) begin
      p = 37'(p * 37'd10);
    end
    return p;
  endfunction

  // (d * w) mod 11 for d, w below 16 with product below 128
  function automatic logic [DIGIT_W-1:0] mul_mod11(input logic [DIGIT_W-1:0] d,
                                                   input logic [DIGIT_W-1:0] w);
    logic [6:0]  p;
    logic [14:0] t;
    logic [3:0]  q;
    logic [6:0]  m;
    p = 7'({3'b000, d} * {3'b000, w});
    t = 15'(p) * 15'd187;
    q = t[14:11];
    m = 7'(p - 7'(7'(q) * 7'(MOD11)));
    return m[DIGIT_W-1:0];
  endfunction

  function automatic logic [DIGIT_W-1:0] add_mod11(input logic [DIGIT_W-1:0] a,
                                                   input logic [DIGIT_W-1:0] b);
    logic [DIGIT_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= {1'b0, MOD11}) begin
      s = s - {1'b0, MOD11};
    end
    return s[DIGIT_W-1:0];
  endfunction

  function automatic logic [DIGIT_W-1:0] check_digit(input logic [DIGIT_W-1:0] r);
    return (r < LOW_R) ? 4'd0 : 4'(MOD11 - r);
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/cpf_digit_stage.sv =====
// ---------------------------------------------------------------------------
// cpf_digit_stage
// one pipeline stage: peels one decimal digit and folds it into both sums
// ---------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module cpf_digit_stage
  import cpf_pkg::*;
#(
  parameter int unsigned POS = 0
) (
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   up_valid,
  output logic        up_ready,
  input  wire stage_t up_data,
  output logic        dn_valid,
  input  wire logic   dn_ready,
  output stage_t      dn_data
);

  localparam logic [ID_W-1:0]    PLACE = pow10(int'(NUM_POS) - int'(POS));
  localparam logic [DIGIT_W-1:0] W1    = (POS < NUM_POS - 1) ? 4'(RADIX - 4'(POS)) : 4'd0;
  localparam logic [DIGIT_W-1:0] W2    = 4'(MOD11 - 4'(POS));

  logic [8:0]         ge;
  logic [DIGIT_W-1:0] digit;
  stage_t             dn_data_next;

  always_comb begin
    for (int k = 1; k < 10; k++) begin
      ge[k-1] = (up_data.x >= 37'(PLACE * 37'(k)));
    end
    digit = 4'($countones(ge));
    dn_data_next.x  = 37'(up_data.x - 37'(PLACE * 37'(digit)));
    dn_data_next.r1 = add_mod11(up_data.r1, mul_mod11(digit, W1));
    dn_data_next.r2 = add_mod11(up_data.r2, mul_mod11(digit, W2));
    dn_data_next.d9 = (POS == NUM_POS - 1) ? digit : up_data.d9;
  end

  assign up_ready = !dn_valid || dn_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (up_ready) begin
      dn_valid <= up_valid;
    end
    if (up_valid && up_ready) begin
      dn_data <= dn_data_next;
    end
  end

  `ASSERT_IMPLIES(a_rest_below_place, clk, rst, dn_valid, dn_data.x < PLACE,
                  "remainder not below digit place")
  `ASSERT_IMPLIES(a_r1_reduced, clk, rst, dn_valid, dn_data.r1 < MOD11,
                  "first sum residue out of range")
  `ASSERT_IMPLIES(a_r2_reduced, clk, rst, dn_valid, dn_data.r2 < MOD11,
                  "second sum residue out of range")

endmodule

`default_nettype wire

// ===== hw/rtl/cpf_check_digit_validator.sv =====
// ---------------------------------------------------------------------------
// cpf_check_digit_validator
// mod-11 check digit validation of an eleven-digit identity number
// ---------------------------------------------------------------------------
// Takes one number per cycle on the slave stream, unless the master side stalls,
// and returns one result per number on the master stream, in order. The path
// is an input register that reduces the value below 10^11, ten digit stages
// that each take off one decimal digit (most significant first) and fold it
// into the running mod-11 residues of both weighted sums, and a result
// register that forms the two check digits and compares them. Sustained rate
// is one number per cycle; stages with no data collapse, so a stalled master
// side fills the pipeline before the slave side stalls.
`default_nettype none

`include "assert_macros.svh"

module cpf_check_digit_validator
  import cpf_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [39:0] s_tdata,   // id_number[36:0]
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [7:0]       m_tdata    // first_check_ok, second_check_ok, valid_res
);

  logic [NUM_POS:0]   valid;
  logic [NUM_POS:0]   ready;
  stage_t [NUM_POS:0] data;
  logic               in_valid;
  stage_t             in_data;
  logic [ID_W-1:0]    id_in;
  logic [ID_W-1:0]    id_reduced;
  logic               ok1;
  logic               ok2;

  assign id_in      = s_tdata[ID_W-1:0];
  assign id_reduced = (id_in >= SPAN) ? 37'(id_in - SPAN) : id_in;
  assign s_tready   = !in_valid || ready[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
    if (s_tvalid && s_tready) begin
      in_data.x  <= id_reduced;
      in_data.r1 <= '0;
      in_data.r2 <= '0;
      in_data.d9 <= '0;
    end
  end

  assign valid[0] = in_valid;
  assign data[0]  = in_data;

  for (genvar i = 0; i < NUM_POS; i++) begin : g_stage
    cpf_digit_stage #(
      .POS (i)
    ) u_stage (
      .clk      (clk),
      .rst      (rst),
      .up_valid (valid[i]),
      .up_ready (ready[i]),
      .up_data  (data[i]),
      .dn_valid (valid[i+1]),
      .dn_ready (ready[i+1]),
      .dn_data  (data[i+1])
    );
  end

  assign ready[NUM_POS] = !m_tvalid || m_tready;
  assign ok1 = (data[NUM_POS].d9 == check_digit(data[NUM_POS].r1));
  assign ok2 = (data[NUM_POS].x[DIGIT_W-1:0] == check_digit(data[NUM_POS].r2));

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (ready[NUM_POS]) begin
      m_tvalid <= valid[NUM_POS];
    end
    if (valid[NUM_POS] && ready[NUM_POS]) begin
      m_tdata <= {5'b00000, ok1 && ok2, ok2, ok1};
    end
  end

  `ASSERT_IMPLIES(a_empty_output_accepts, clk, rst, !m_tvalid, s_tready,
                  "input stalled with output register empty")
  `ASSERT_IMPLIES(a_valid_is_and, clk, rst, m_tvalid,
                  m_tdata[2] == (m_tdata[0] && m_tdata[1]),
                  "overall flag disagrees with check flags")
  `ASSERT_IMPLIES(a_input_reduced, clk, rst, in_valid, in_data.x < SPAN,
                  "input value not reduced below eleven digits")
  `ASSERT_IMPLIES(a_last_digit, clk, rst, valid[NUM_POS],
                  data[NUM_POS].x < 37'(RADIX),
                  "last remainder is not a single digit")

endmodule

`default_nettype wire

// ===== sim/testbench.sv =====
// ---------------------------------------------------------------------------
// testbench
// self-checking bench for the cpf check digit validator
// ---------------------------------------------------------------------------
// Streams eleven-digit identity numbers into the block and checks every
// verdict against a mod-11 digit predictor kept in a small scoreboard class.
// A directed set covers zeros, the 37-bit maximum, values above eleven
// digits, short numbers and check digits forced to zero by a low remainder.
// Random numbers follow, mostly well-formed with one or both check digits
// corrupted at random, with idle bursts on both streams except near the end.
`default_nettype none

module testbench;
  import cpf_pkg::*;

  typedef logic [10:0][3:0] digits_t;

  typedef struct packed {
    logic first_ok;
    logic second_ok;
    logic both_ok;
  } verdict_t;

  class cpf_verdict_board;
    verdict_t pending_verdicts[$];
    int       errors;
    int       noted;
    int       checked;
    int       accepted;

    // d[0] is the most significant of the low eleven decimal digits
    static function digits_t to_digits(input longint unsigned v);
      digits_t d;
      v = v % 64'd100000000000;
      for (int k = 10; k >= 0; k--) begin
        d[k] = 4'(v % 10);
        v = v / 10;
      end
      return d;
    endfunction

    // weights n+1 down to 2 over the first n digits
    static function int unsigned weighted(input digits_t d, input int n);
      int unsigned s;
      s = 0;
      for (int k = 0; k < n; k++) begin
        s += d[k] * (n + 1 - k);
      end
      return s;
    endfunction

    static function logic [3:0] check_of(input int unsigned s);
      int unsigned r;
      r = s % 11;
      return (r < 2) ? 4'd0 : 4'(11 - r);
    endfunction

    function void note_number(input logic [ID_W-1:0] id);
      digits_t  d;
      verdict_t v;
      d = to_digits(64'(id));
      v.first_ok  = (d[9] == check_of(weighted(d, 9)));
      v.second_ok = (d[10] == check_of(weighted(d, 10)));
      v.both_ok   = v.first_ok & v.second_ok;
      pending_verdicts.push_back(v);
      noted++;
    endfunction

    task report(input string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      errors++;
    endtask

    task check_verdict(input logic [7:0] data);
      verdict_t want;
      if (pending_verdicts.size() == 0) begin
        report($sformatf("unexpected transfer, data %02h", data));
      end else begin
        want = pending_verdicts.pop_front();
        checked++;
        if (data[0] !== want.first_ok)
          report($sformatf("first_check_ok %b, want %b", data[0], want.first_ok));
        if (data[1] !== want.second_ok)
          report($sformatf("second_check_ok %b, want %b", data[1], want.second_ok));
        if (data[2] !== want.both_ok)
          report($sformatf("valid_res %b, want %b", data[2], want.both_ok));
        if (data[7:3] !== 5'd0)
          report($sformatf("padding bits %b not zero", data[7:3]));
        if (want.both_ok)
          accepted++;
      end
    endtask
  endclass

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [39:0] s_tdata;   // id_number[36:0]
  logic        m_tvalid;
  logic        m_tready;
  logic [7:0]  m_tdata;   // first_check_ok, second_check_ok, valid_res

  cpf_verdict_board sb = new;
  bit               tx_idle_on;
  bit               rx_idle_on;

  cpf_check_digit_validator dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #3000000;
    $display("Test completed with failures");
    $finish;
  end

  // builds a number from nine base digits, optionally spoiling a check digit
  function automatic longint unsigned make_id(input int unsigned base, input bit bad1,
                                              input bit bad2);
    digits_t     d;
    logic [3:0]  c;
    d = cpf_verdict_board::to_digits(64'(base) * 100);
    c = cpf_verdict_board::check_of(cpf_verdict_board::weighted(d, 9));
    d[9] = bad1 ? 4'((c + $urandom_range(1, 9)) % 10) : c;
    c = cpf_verdict_board::check_of(cpf_verdict_board::weighted(d, 10));
    d[10] = bad2 ? 4'((c + $urandom_range(1, 9)) % 10) : c;
    return 64'(base) * 100 + d[9] * 10 + d[10];
  endfunction

  // valid number whose n-digit weighted sum leaves remainder zero or one
  function automatic longint unsigned low_remainder_id(input int n);
    longint unsigned id;
    do begin
      id = make_id($urandom_range(0, 999999999), 1'b0, 1'b0);
    end while (cpf_verdict_board::weighted(cpf_verdict_board::to_digits(id), n) % 11 >= 2);
    return id;
  endfunction

  function automatic longint unsigned random_id();
    longint unsigned id;
    id = {27'd0, 5'($urandom_range(0, 31)), $urandom()};
    case ($urandom_range(0, 9))
      0, 1, 2, 3: id = make_id($urandom_range(0, 999999999), 1'b0, 1'b0);
      4, 5:       id = make_id($urandom_range(0, 999999999), 1'($urandom_range(0, 1)),
                               1'b1);
      6:          id = make_id($urandom_range(0, 999999999), 1'b1, 1'b0);
      7:          id = id % 64'd100000000000;
      8:          id = id;
      default:    id = make_id($urandom_range(0, 9999), 1'($urandom_range(0, 1)),
                               1'($urandom_range(0, 1)));
    endcase
    return id;
  endfunction

  // called at a falling edge, returns at the falling edge after the transfer
  task automatic send_number(input longint unsigned id);
    if (tx_idle_on && $urandom_range(0, 3) == 0) begin
      s_tvalid = 1'b0;
      s_tdata  = {$urandom(), 8'($urandom())};
      repeat ($urandom_range(1, 10)) @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tdata  = {3'b000, id[ID_W-1:0]};
    do @(posedge clk); while (!s_tready);
    sb.note_number(id[ID_W-1:0]);
    @(negedge clk);
  endtask

  initial begin
    int stall_left;
    stall_left = 0;
    m_tready   = 1'b0;
    @(negedge clk);
    forever begin
      if (stall_left > 0) begin
        m_tready = 1'b0;
        stall_left--;
      end else if (rx_idle_on && $urandom_range(0, 7) == 0) begin
        m_tready = 1'b0;
        stall_left = $urandom_range(0, 9);
      end else begin
        m_tready = 1'b1;
      end
      @(negedge clk);
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready)
      sb.check_verdict(m_tdata);
  end

  initial begin
    rst        = 1'b1;
    s_tvalid   = 1'b0;
    s_tdata    = '0;
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    send_number(64'd0);
    send_number(64'd137438953471);
    send_number(64'd99999999999);
    send_number(64'd100000000000);
    send_number(64'd52998224725);
    send_number(64'd52998224726);
    send_number(64'd191);
    send_number(64'd1);
    send_number(64'd100000000000 + make_id($urandom_range(0, 999999999), 1'b0, 1'b0));
    send_number(64'd137438953471 - $urandom_range(0, 999));
    send_number(low_remainder_id(9));
    send_number(low_remainder_id(9));
    send_number(low_remainder_id(10));
    send_number(low_remainder_id(10));
    send_number(make_id(999999999, 1'b0, 1'b0));
    send_number(make_id(0, 1'b1, 1'b0));
    send_number(make_id(123456789, 1'b0, 1'b1));
    send_number(make_id(987654321, 1'b1, 1'b1));
    send_number(make_id(5, 1'b0, 1'b0));
    send_number(64'h1F_FFFF_FFFF ^ (64'd1 << $urandom_range(0, 36)));

    for (int i = 0; i < 750; i++) begin
      if (i == 375) begin
        s_tvalid = 1'b0;
        while (sb.pending_verdicts.size() != 0) @(negedge clk);
      end
      send_number(random_id());
    end

    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    for (int i = 0; i < 150; i++) begin
      send_number(random_id());
    end
    s_tvalid = 1'b0;

    while (sb.pending_verdicts.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (sb.pending_verdicts.size() != 0)
      sb.report($sformatf("%0d verdicts never arrived", sb.pending_verdicts.size()));

    $display("%0d numbers sent, %0d verdicts checked, %0d of them valid",
             sb.noted, sb.checked, sb.accepted);
    $display("covered zero check digits, values above eleven digits, short numbers");
    if (sb.errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/cpf_pkg.sv
hw/rtl/cpf_digit_stage.sv
hw/rtl/cpf_check_digit_validator.sv
sim/testbench.sv
